// ----- rtl/core/jan_pkg.sv -----
package jan_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam logic [15:0] SAMPLE_MASK = 16'((64'd1 << SAMPLE_BITS) - 64'd1);

	localparam logic signed [15:0] FULL_SCALE = 16'sd32767;

	// quotient is always below 2^15, so the top dividend bits preload the remainder
	localparam int QUO_BITS = 15;
	localparam int CNT_BITS = $clog2(QUO_BITS);

	typedef enum logic [2:0] {
		REG_RANGE_MIN    = 3'd0,
		REG_RANGE_CENTER = 3'd1,
		REG_RANGE_MAX    = 3'd2,
		REG_DEAD_WIDTH   = 3'd3,
		REG_MIN_CHANGE   = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [15:0] range_min;
		logic [15:0] range_center;
		logic [15:0] range_max;
		logic [14:0] dead_width;
		logic [15:0] min_change;
	} cfg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SETUP,
		ST_DIV,
		ST_FILT
	} state_t;

endpackage

// ----- rtl/core/jan_cfg.sv -----
module jan_cfg
	import jan_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [15:0] cfg_wdata,
	output cfg_t        cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.range_min    <= 16'd0;
			cfg_q.range_center <= 16'd32768;
			cfg_q.range_max    <= 16'd65535;
			cfg_q.dead_width   <= 15'd0;
			cfg_q.min_change   <= 16'd256;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_idx))
				REG_RANGE_MIN:    cfg_q.range_min    <= cfg_wdata;
				REG_RANGE_CENTER: cfg_q.range_center <= cfg_wdata;
				REG_RANGE_MAX:    cfg_q.range_max    <= cfg_wdata;
				REG_DEAD_WIDTH:   cfg_q.dead_width   <= cfg_wdata[14:0];
				REG_MIN_CHANGE:   cfg_q.min_change   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- rtl/core/jan_div.sv -----
module jan_div
	import jan_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [15:0]         dvd_hi,
	input  logic [QUO_BITS-1:0] dvd_lo,
	input  logic [15:0]         den,
	output logic                done,
	output logic [QUO_BITS-1:0] quo
);

	logic [15:0]         rem_q;
	logic [QUO_BITS-1:0] quo_q;
	logic [15:0]         den_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                busy_q;
	logic                done_q;

	logic [16:0] trial;
	logic [16:0] diff;
	logic        qbit;

	// restoring divide: one quotient bit per cycle, dividend bits shift out of quo_q
	always_comb begin
		trial = {rem_q, quo_q[QUO_BITS-1]};
		diff  = trial - {1'b0, den_q};
		qbit  = !diff[16];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_BITS'(QUO_BITS - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dvd_hi;
			quo_q <= dvd_lo;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= qbit ? diff[15:0] : trial[15:0];
			quo_q <= {quo_q[QUO_BITS-2:0], qbit};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

// ----- rtl/core/joystick_axis_normalizer.sv -----
// channel  dir  handshake            payload
// in       in   in_valid / in_stall  axis_sel, raw_sample
// out      out  out_valid / out_stall event_axis, axis_value, axis_delta
// cfg      in   cfg_we               cfg_idx, cfg_wdata
//
// A word on a slope goes from acceptance through setup, the divider steps, a done
// step and the filter to its decision; clamped and dead band words go from setup
// straight to the filter. in_stall is high until the decision, so the next word
// is taken only once the block is through with the previous one.
// A result waits in the output register while the next word is taken;
// a second result waits in the filter step until the register frees.
// arst_n clears config to defaults and both axes to "nothing reported".
module joystick_axis_normalizer
	import jan_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               axis_sel,
	input  logic [15:0]        raw_sample,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               event_axis,
	output logic signed [15:0] axis_value,
	output logic signed [16:0] axis_delta,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_idx,
	input  logic [15:0]        cfg_wdata
);

	cfg_t cfg;

	state_t state_q, state_d;

	logic               axis_q;
	logic [15:0]        raw_q;
	logic               neg_q;
	logic signed [15:0] val_q;
	logic signed [15:0] last_q [2];
	logic [1:0]         seen_q;

	logic               out_valid_q;
	logic               out_axis_q;
	logic signed [15:0] out_value_q;
	logic signed [16:0] out_delta_q;

	logic                div_start;
	logic                div_done;
	logic [QUO_BITS-1:0] quo;

	// setup arithmetic
	logic signed [17:0] s, lo, hi, lo_edge, hi_edge;
	logic signed [17:0] num_w, den_w;
	logic               is_min, is_max, is_dead, is_neg;
	logic [15:0]        num, den;
	logic [30:0]        prod;
	logic signed [15:0] const_val;

	// filter
	logic signed [15:0] last;
	logic signed [16:0] delta;
	logic [16:0]        mag;
	logic               drop;
	logic               out_free;
	logic               load_out;

	jan_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	always_comb begin
		s       = {2'b00, raw_q};
		lo      = {2'b00, cfg.range_min};
		hi      = {2'b00, cfg.range_max};
		lo_edge = {2'b00, cfg.range_center} - {3'b000, cfg.dead_width};
		hi_edge = {2'b00, cfg.range_center} + {3'b000, cfg.dead_width};
		is_min  = s <= lo;
		is_max  = s >= hi;
		is_dead = (s >= lo_edge) && (s <= hi_edge);
		is_neg  = s < lo_edge;
		num_w   = is_neg ? (lo_edge - s) : (s - hi_edge);
		den_w   = is_neg ? (lo_edge - lo) : (hi - hi_edge);
		num     = num_w[15:0];
		den     = den_w[15:0];
		// 32767 * num as a shift and subtract
		prod    = {num, 15'd0} - 31'(num);
		if (is_min)
			const_val = -FULL_SCALE;
		else if (is_max)
			const_val = FULL_SCALE;
		else
			const_val = 16'sd0;
	end

	jan_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.dvd_hi (prod[30:15]),
		.dvd_lo (prod[14:0]),
		.den    (den),
		.done   (div_done),
		.quo    (quo)
	);

	always_comb begin
		last     = last_q[axis_q];
		delta    = 17'(val_q) - 17'(last);
		mag      = delta[16] ? 17'(-delta) : 17'(delta);
		drop     = seen_q[axis_q] && ((val_q == last) ||
			((val_q != 16'sd0) && (last != 16'sd0) && (mag < {1'b0, cfg.min_change})));
		out_free = !out_valid_q || !out_stall;
	end

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid)
					state_d = ST_SETUP;
			end
			ST_SETUP: begin
				if (is_min || is_max || is_dead) begin
					state_d = ST_FILT;
				end else begin
					div_start = 1'b1;
					state_d   = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_done)
					state_d = ST_FILT;
			end
			ST_FILT: begin
				if (drop) begin
					state_d = ST_IDLE;
				end else if (out_free) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			axis_q <= axis_sel;
			raw_q  <= raw_sample & SAMPLE_MASK;
		end
		if (state_q == ST_SETUP) begin
			neg_q <= is_neg;
			val_q <= const_val;
		end
		if (state_q == ST_DIV && div_done)
			val_q <= neg_q ? -16'(quo) : 16'(quo);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q    <= 2'b00;
			last_q[0] <= 16'sd0;
			last_q[1] <= 16'sd0;
		end else if (load_out) begin
			seen_q[axis_q] <= 1'b1;
			last_q[axis_q] <= val_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load_out)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	// first report of an axis carries the value itself as delta
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_axis_q  <= axis_q;
			out_value_q <= val_q;
			out_delta_q <= seen_q[axis_q] ? delta : 17'(val_q);
		end
	end

	assign in_stall   = (state_q != ST_IDLE);
	assign out_valid  = out_valid_q;
	assign event_axis = out_axis_q;
	assign axis_value = out_value_q;
	assign axis_delta = out_delta_q;

endmodule

// ----- tb/tb_joystick_axis_normalizer.sv -----
`timescale 1ns / 1ps

module tb_joystick_axis_normalizer;
	import jan_pkg::*;

	localparam int SETTLE_CYCLES = 40;
	localparam int PHASES        = 8;
	localparam int PHASE_WORDS   = 62;

	typedef struct {
		logic               ax;
		logic signed [15:0] val;
		logic signed [16:0] dlt;
	} axis_event_t;

	class axis_event_board;
		logic [15:0]        rmin, rcenter, rmax, mchange;
		logic [14:0]        dwidth;
		logic signed [15:0] last_val [2];
		bit                 seen [2];
		axis_event_t        pending_q [$];
		int                 errors;

		function new();
			rmin = 16'd0;
			rcenter = 16'd32768;
			rmax = 16'd65535;
			dwidth = 15'd0;
			mchange = 16'd256;
			last_val[0] = '0;
			last_val[1] = '0;
			seen[0] = 1'b0;
			seen[1] = 1'b0;
			errors = 0;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [15:0] data);
			case (idx)
				REG_RANGE_MIN:    rmin = data;
				REG_RANGE_CENTER: rcenter = data;
				REG_RANGE_MAX:    rmax = data;
				REG_DEAD_WIDTH:   dwidth = data[14:0];
				REG_MIN_CHANGE:   mchange = data;
				default: ;
			endcase
		endfunction

		// limits first, then the dead band, then the slopes; edges may fall outside 0..65535
		function logic signed [15:0] scale_sample(logic [15:0] raw);
			longint s, lo, hi, lo_e, hi_e, q;
			s = longint'(raw & SAMPLE_MASK);
			lo = longint'(rmin);
			hi = longint'(rmax);
			lo_e = longint'(rcenter) - longint'(dwidth);
			hi_e = longint'(rcenter) + longint'(dwidth);
			if (s <= lo)
				return -FULL_SCALE;
			if (s >= hi)
				return FULL_SCALE;
			if (s >= lo_e && s <= hi_e)
				return '0;
			if (s < lo_e)
				q = -((longint'(FULL_SCALE) * (lo_e - s)) / (lo_e - lo));
			else
				q = (longint'(FULL_SCALE) * (s - hi_e)) / (hi - hi_e);
			return q[15:0];
		endfunction

		function void note_sample(logic ax, logic [15:0] raw);
			logic signed [15:0] v;
			logic signed [16:0] d;
			int                 mag;
			axis_event_t        e;
			v = scale_sample(raw);
			d = 17'(v);
			if (seen[ax]) begin
				d = 17'(int'(v) - int'(last_val[ax]));
				mag = (d < 0) ? -int'(d) : int'(d);
				if (v == last_val[ax])
					return;
				if (v != 0 && last_val[ax] != 0 && mag < int'(mchange))
					return;
			end
			last_val[ax] = v;
			seen[ax] = 1'b1;
			e.ax = ax;
			e.val = v;
			e.dlt = d;
			pending_q.push_back(e);
		endfunction

		function void check_event(logic ax, logic signed [15:0] v, logic signed [16:0] d);
			axis_event_t e;
			if (pending_q.size() == 0) begin
				$error("unexpected event: axis %0d value %0d delta %0d", ax, v, d);
				errors++;
				return;
			end
			e = pending_q.pop_front();
			if (ax !== e.ax) begin
				$error("event_axis: expected %0d, got %0d", e.ax, ax);
				errors++;
			end
			if (v !== e.val) begin
				$error("axis_value: expected %0d, got %0d", e.val, v);
				errors++;
			end
			if (d !== e.dlt) begin
				$error("axis_delta: expected %0d, got %0d", e.dlt, d);
				errors++;
			end
		endfunction

		function int waiting();
			return pending_q.size();
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic               axis_sel;
	logic [15:0]        raw_sample;
	logic               out_valid;
	logic               out_stall;
	logic               event_axis;
	logic signed [15:0] axis_value;
	logic signed [16:0] axis_delta;
	logic               cfg_we;
	logic [2:0]         cfg_idx;
	logic [15:0]        cfg_wdata;

	axis_event_board sb = new();
	bit              calm;
	int              prev_raw [2];

	joystick_axis_normalizer dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.axis_sel   (axis_sel),
		.raw_sample (raw_sample),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.event_axis (event_axis),
		.axis_value (axis_value),
		.axis_delta (axis_delta),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_wdata  (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("FAILURE");
		$finish;
	end

	// mostly short gaps, now and then a long one; none at all in calm phases
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// random samples biased towards the range ends, dead band edges and small steps
	function automatic logic [15:0] next_raw(logic ax);
		int kind;
		int r;
		kind = $urandom_range(0, 99);
		if (kind < 30)
			r = $urandom_range(0, 65535);
		else if (kind < 55)
			r = prev_raw[ax] + int'($urandom_range(0, 600)) - 300;
		else if (kind < 65)
			r = prev_raw[ax];
		else if (kind < 85) begin
			case ($urandom_range(0, 3))
				0: r = int'(sb.rmin);
				1: r = int'(sb.rmax);
				2: r = int'(sb.rcenter) - int'(sb.dwidth);
				default: r = int'(sb.rcenter) + int'(sb.dwidth);
			endcase
			r = r + int'($urandom_range(0, 6)) - 3;
		end else
			r = $urandom_range(0, 1) ? 65535 : 0;
		if (r < 0)
			r = 0;
		if (r > 65535)
			r = 65535;
		prev_raw[ax] = r;
		return r[15:0];
	endfunction

	task automatic send_sample(input logic ax, input logic [15:0] raw);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		axis_sel = ax;
		raw_sample = raw;
		in_valid = 1'b1;
		forever begin
			@(posedge clk);
			if (!in_stall)
				break;
		end
		sb.note_sample(ax, raw);
		@(negedge clk);
	endtask

	// wait out every expected word, then the latency of a word that gives none
	task automatic settle_block();
		in_valid = 1'b0;
		while (sb.waiting() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [15:0] data);
		cfg_we = 1'b1;
		cfg_idx = idx;
		cfg_wdata = data;
		@(negedge clk);
		cfg_we = 1'b0;
		sb.write_reg(idx, data);
	endtask

	task automatic program_settings(input logic [15:0] rmin, input logic [15:0] rcenter,
			input logic [15:0] rmax, input logic [14:0] dw, input logic [15:0] mc);
		settle_block();
		write_reg(REG_RANGE_MIN, rmin);
		write_reg(REG_RANGE_CENTER, rcenter);
		write_reg(REG_RANGE_MAX, rmax);
		write_reg(REG_DEAD_WIDTH, {1'b0, dw});
		write_reg(REG_MIN_CHANGE, mc);
	endtask

	task automatic random_settings(input int p);
		logic [15:0] rmin, rcenter, rmax, mc;
		logic [14:0] dw;
		rmin = 16'($urandom_range(0, 20000));
		rmax = 16'($urandom_range(45000, 65535));
		rcenter = 16'($urandom_range(rmin, rmax));
		dw = 15'($urandom_range(0, 3000));
		case ($urandom_range(0, 3))
			0: mc = 16'd0;
			1: mc = 16'd1;
			2: mc = 16'($urandom_range(0, 1000));
			default: mc = 16'($urandom_range(0, 65535));
		endcase
		if (p == 0)
			program_settings(16'd0, 16'($urandom_range(0, 65535)), 16'd65535, 15'd32767,
				16'd0);
		else if (p == 1)
			program_settings(16'd0, 16'd32768, 16'd65535, 15'd0, 16'd65535);
		else if ($urandom_range(0, 3) == 0)
			program_settings(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
				16'($urandom_range(0, 65535)), 15'($urandom_range(0, 32767)),
				16'($urandom_range(0, 65535)));
		else
			program_settings(rmin, rcenter, rmax, dw, mc);
	endtask

	initial begin
		logic ax;
		arst_n = 1'b0;
		in_valid = 1'b0;
		axis_sel = 1'b0;
		raw_sample = '0;
		cfg_we = 1'b0;
		cfg_idx = REG_RANGE_MIN;
		cfg_wdata = '0;
		calm = 1'b0;
		prev_raw[0] = 32768;
		prev_raw[1] = 32768;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset settings: first reports, full swings, repeats, sub-threshold moves,
		// a slope word truncated to zero
		send_sample(1'b0, 16'd0);
		send_sample(1'b0, 16'd65535);
		send_sample(1'b1, 16'd32768);
		send_sample(1'b1, 16'd32768);
		send_sample(1'b1, 16'd0);
		send_sample(1'b0, 16'd65534);
		send_sample(1'b0, 16'd32769);
		send_sample(1'b0, 16'd32767);
		send_sample(1'b0, 16'd32770);
		send_sample(1'b0, 16'd32900);
		send_sample(1'b1, 16'd1);
		send_sample(1'b1, 16'd65535);
		send_sample(1'b1, 16'd0);

		// narrow range with a dead band, every change reported
		program_settings(16'd100, 16'd1000, 16'd2000, 15'd200, 16'd0);
		send_sample(1'b0, 16'd100);
		send_sample(1'b0, 16'd99);
		send_sample(1'b0, 16'd2000);
		send_sample(1'b0, 16'd800);
		send_sample(1'b1, 16'd1200);
		send_sample(1'b1, 16'd799);
		send_sample(1'b1, 16'd1201);
		send_sample(1'b1, 16'd1500);
		send_sample(1'b1, 16'd1501);
		send_sample(1'b1, 16'd1501);

		// minimum above maximum, dead band running below zero
		program_settings(16'd60000, 16'd0, 16'd10000, 15'd32767, 16'd65535);
		send_sample(1'b0, 16'd60000);
		send_sample(1'b0, 16'd60001);
		send_sample(1'b1, 16'd0);
		send_sample(1'b1, 16'd65535);

		for (int p = 0; p < PHASES; p++) begin
			random_settings(p);
			calm = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < PHASE_WORDS; i++) begin
				ax = 1'($urandom_range(0, 1));
				send_sample(ax, next_raw(ax));
			end
		end
		calm = 1'b0;

		settle_block();
		if (sb.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		int stall_left;
		stall_left = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall)
				sb.check_event(event_axis, axis_value, axis_delta);
			@(negedge clk);
			if (stall_left > 0) begin
				out_stall = 1'b1;
				stall_left--;
			end else begin
				out_stall = 1'b0;
				stall_left = pick_gap();
			end
		end
	end

endmodule
